>>> src/lbbt_pkg.sv
// Shared constants, types and codes of the label bounding box tracker.
package lbbt_pkg;

   localparam int MAP_WIDTH  = 2048;
   localparam int MAP_HEIGHT = 1024;
   localparam int MAX_LABELS = 64;

   localparam int X_W      = 11;
   localparam int Y_W      = 10;
   localparam int LAB_W    = 8;
   localparam int REG_W    = 6;
   localparam int SLOTS    = 2 ** REG_W;
   localparam int CSR_W    = 8;
   localparam int CSR_A_W  = 2;
   localparam int REQ_D_W  = 32;
   localparam int RSP_D_W  = 72;
   localparam int RSP_PAD  = RSP_D_W - (REG_W + 3 * X_W + 3 * Y_W);

   typedef enum logic [1:0] {
      ACT_PIXEL  = 2'd0,
      ACT_REPORT = 2'd1,
      ACT_CLEAR  = 2'd2,
      ACT_NONE   = 2'd3
   } action_type;

   typedef enum logic [CSR_A_W-1:0] {
      CSR_FIRST  = 2'd0,
      CSR_LAST   = 2'd1,
      CSR_SEA    = 2'd2,
      CSR_BORDER = 2'd3
   } csr_type;

   typedef enum logic [1:0] {
      KIND_PIXEL  = 2'd0,
      KIND_REPORT = 2'd1,
      KIND_CLEAR  = 2'd2
   } kind_type;

   typedef struct packed {
      logic [X_W-1:0] min_col;
      logic [Y_W-1:0] min_row;
      logic [X_W-1:0] max_col;
      logic [Y_W-1:0] max_row;
   } box_type;

   localparam int BOX_W = $bits(box_type);

   localparam box_type BOX_RESET = '{
      min_col: {X_W{1'b1}},
      min_row: {Y_W{1'b1}},
      max_col: '0,
      max_row: '0
   };

   // One operation handed from the sequencer to the update stage.
   typedef struct packed {
      logic             valid;
      kind_type         kind;
      logic [REG_W-1:0] slot;
      logic [X_W-1:0]   x;
      logic [Y_W-1:0]   y;
      logic             last;
   } issue_type;

   // One box read out for a report.
   typedef struct packed {
      logic             valid;
      logic [REG_W-1:0] region;
      box_type          box;
      logic             last;
   } report_type;

endpackage

>>> src/lbbt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module lbbt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Read returns the old contents when the same entry is written in that cycle.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> src/lbbt_ctrl.sv
// Configuration registers, pixel filter and report sequencer.
module lbbt_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [1:0]                  req_tuser,
   input  logic [lbbt_pkg::REQ_D_W-1:0] req_tdata,
   input  logic                        csr_we,
   input  logic [lbbt_pkg::CSR_A_W-1:0] csr_addr,
   input  logic [lbbt_pkg::CSR_W-1:0]  csr_wdata,
   input  logic                        advance,
   output lbbt_pkg::issue_type         issue
);

   typedef enum logic {ST_IDLE, ST_REPORT} state_type;

   state_type                    state_ff, state_in;
   logic [lbbt_pkg::REG_W-1:0]   cnt_ff, cnt_in;
   logic [lbbt_pkg::REG_W-1:0]   first_ff, first_in;
   logic [lbbt_pkg::REG_W-1:0]   last_ff, last_in;
   logic [lbbt_pkg::LAB_W-1:0]   sea_ff, sea_in;
   logic [lbbt_pkg::LAB_W-1:0]   border_ff, border_in;

   logic [lbbt_pkg::REG_W-1:0]   hi;
   lbbt_pkg::action_type         action;
   logic [lbbt_pkg::X_W-1:0]     px;
   logic [lbbt_pkg::Y_W-1:0]     py;
   logic [lbbt_pkg::LAB_W-1:0]   lab;
   logic                         pix_pass;
   logic                         accept;

   assign action = lbbt_pkg::action_type'(req_tuser);
   assign px     = req_tdata[lbbt_pkg::X_W-1:0];
   assign py     = req_tdata[lbbt_pkg::X_W +: lbbt_pkg::Y_W];
   assign lab    = req_tdata[lbbt_pkg::X_W + lbbt_pkg::Y_W +: lbbt_pkg::LAB_W];

   // Cut the range at the top slot.
   assign hi = (last_ff > lbbt_pkg::REG_W'(lbbt_pkg::MAX_LABELS - 1)) ?
               lbbt_pkg::REG_W'(lbbt_pkg::MAX_LABELS - 1) : last_ff;

   assign pix_pass = ({1'b0, px} < (lbbt_pkg::X_W + 1)'(lbbt_pkg::MAP_WIDTH))
                  && ({1'b0, py} < (lbbt_pkg::Y_W + 1)'(lbbt_pkg::MAP_HEIGHT))
                  && (lab != sea_ff) && (lab != border_ff)
                  && (lab >= {2'b00, first_ff}) && (lab <= {2'b00, hi});

   assign req_tready = (state_ff == ST_IDLE) && advance;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      issue       = '0;
      issue.slot  = lab[lbbt_pkg::REG_W-1:0];
      issue.x     = px;
      issue.y     = py;
      issue.kind  = lbbt_pkg::KIND_PIXEL;
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            case (action)
               lbbt_pkg::ACT_PIXEL: begin
                  issue.valid = req_tvalid && pix_pass;
               end
               lbbt_pkg::ACT_CLEAR: begin
                  issue.valid = req_tvalid;
                  issue.kind  = lbbt_pkg::KIND_CLEAR;
               end
               lbbt_pkg::ACT_REPORT: begin
                  if (accept && (first_ff <= hi)) begin
                     state_in = ST_REPORT;
                     cnt_in   = first_ff;
                  end
               end
               default: begin
               end
            endcase
         end
         ST_REPORT: begin
            issue.valid = 1'b1;
            issue.kind  = lbbt_pkg::KIND_REPORT;
            issue.slot  = cnt_ff;
            issue.last  = (cnt_ff == hi);
            if (advance) begin
               if (cnt_ff == hi) begin
                  state_in = ST_IDLE;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      first_in  = first_ff;
      last_in   = last_ff;
      sea_in    = sea_ff;
      border_in = border_ff;
      if (csr_we) begin
         unique case (lbbt_pkg::csr_type'(csr_addr))
            lbbt_pkg::CSR_FIRST:  first_in  = csr_wdata[lbbt_pkg::REG_W-1:0];
            lbbt_pkg::CSR_LAST:   last_in   = csr_wdata[lbbt_pkg::REG_W-1:0];
            lbbt_pkg::CSR_SEA:    sea_in    = csr_wdata;
            lbbt_pkg::CSR_BORDER: border_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         cnt_ff    <= '0;
         first_ff  <= '0;
         last_ff   <= {lbbt_pkg::REG_W{1'b1}};
         sea_ff    <= '0;
         border_ff <= {lbbt_pkg::LAB_W{1'b1}};
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         first_ff  <= first_in;
         last_ff   <= last_in;
         sea_ff    <= sea_in;
         border_ff <= border_in;
      end
   end

   a_report_blocks_req: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_REPORT) |-> !req_tready)
      else $error("request taken during a report");

   a_cnt_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_REPORT) |-> ((cnt_ff >= first_ff) && (cnt_ff <= hi)))
      else $error("report counter left the tracked range");

   a_empty_report: assert property (@(posedge clock) disable iff (reset)
      (accept && (action == lbbt_pkg::ACT_REPORT) && (first_ff > hi))
      |=> (state_ff == ST_IDLE))
      else $error("empty range started a report");

endmodule

>>> src/lbbt_update.sv
// Read-modify-write stage: entry valid bits, forwarding and box widening.
module lbbt_update (
   input  logic                         clock,
   input  logic                         reset,
   input  lbbt_pkg::issue_type          issue,
   input  logic [lbbt_pkg::BOX_W-1:0]   ram_rdata,
   input  logic                         slot_free,
   output logic                         advance,
   output logic                         ram_we,
   output logic [lbbt_pkg::REG_W-1:0]   ram_waddr,
   output logic [lbbt_pkg::BOX_W-1:0]   ram_wdata,
   output lbbt_pkg::report_type         report
);

   lbbt_pkg::issue_type          s1_ff, s1_in;
   logic [lbbt_pkg::SLOTS-1:0]   valid_bits_ff, valid_bits_in;
   logic                         fwd_valid_ff, fwd_valid_in;
   logic [lbbt_pkg::REG_W-1:0]   fwd_slot_ff, fwd_slot_in;
   lbbt_pkg::box_type            fwd_box_ff, fwd_box_in;

   lbbt_pkg::box_type            cur;
   lbbt_pkg::box_type            merged;
   logic                         write;
   logic                         clear;

   assign advance = !s1_ff.valid || (s1_ff.kind != lbbt_pkg::KIND_REPORT) || slot_free;
   assign write   = s1_ff.valid && (s1_ff.kind == lbbt_pkg::KIND_PIXEL);
   assign clear   = s1_ff.valid && (s1_ff.kind == lbbt_pkg::KIND_CLEAR);

   // Take the box just written when the read raced it; never-written entries read as reset.
   always_comb begin
      if (fwd_valid_ff && (fwd_slot_ff == s1_ff.slot)) begin
         cur = fwd_box_ff;
      end else if (valid_bits_ff[s1_ff.slot]) begin
         cur = lbbt_pkg::box_type'(ram_rdata);
      end else begin
         cur = lbbt_pkg::BOX_RESET;
      end
   end

   always_comb begin
      merged = cur;
      if (s1_ff.x < cur.min_col) merged.min_col = s1_ff.x;
      if (s1_ff.y < cur.min_row) merged.min_row = s1_ff.y;
      if (s1_ff.x > cur.max_col) merged.max_col = s1_ff.x;
      if (s1_ff.y > cur.max_row) merged.max_row = s1_ff.y;
   end

   assign ram_we    = write;
   assign ram_waddr = s1_ff.slot;
   assign ram_wdata = merged;

   always_comb begin
      report.valid  = s1_ff.valid && (s1_ff.kind == lbbt_pkg::KIND_REPORT);
      report.region = s1_ff.slot;
      report.box    = cur;
      report.last   = s1_ff.last;
   end

   always_comb begin
      valid_bits_in = valid_bits_ff;
      if (clear) begin
         valid_bits_in = '0;
      end else if (write) begin
         valid_bits_in[s1_ff.slot] = 1'b1;
      end
   end

   always_comb begin
      s1_in        = s1_ff;
      fwd_valid_in = fwd_valid_ff;
      fwd_slot_in  = fwd_slot_ff;
      fwd_box_in   = fwd_box_ff;
      if (advance) begin
         s1_in        = issue;
         fwd_valid_in = write;
         fwd_slot_in  = s1_ff.slot;
         fwd_box_in   = merged;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff         <= '0;
         valid_bits_ff <= '0;
         fwd_valid_ff  <= 1'b0;
      end else begin
         s1_ff         <= s1_in;
         valid_bits_ff <= valid_bits_in;
         fwd_valid_ff  <= fwd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fwd_slot_ff <= fwd_slot_in;
      fwd_box_ff  <= fwd_box_in;
   end

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_ff.valid && (s1_ff.kind == lbbt_pkg::KIND_REPORT) && !slot_free)
      |=> (s1_ff.valid && (s1_ff.kind == lbbt_pkg::KIND_REPORT) && $stable(s1_ff.slot)))
      else $error("stalled report entry lost");

   a_clear_all: assert property (@(posedge clock) disable iff (reset)
      clear |=> (valid_bits_ff == '0))
      else $error("clear left entries marked written");

   a_forward_set: assert property (@(posedge clock) disable iff (reset)
      write |=> (fwd_valid_ff && (fwd_slot_ff == $past(s1_ff.slot))
                 && valid_bits_ff[fwd_slot_ff]))
      else $error("write not recorded for forwarding");

endmodule

>>> src/label_bounding_box_tracker.sv
// Top level of the per-label bounding box tracker.
//
// Requests arrive on req_ (tvalid/tready/tdata/tuser). tuser carries the action:
// pixel update, report all boxes, clear all boxes; the unused code is dropped.
// A pixel widens the box of its label unless the label is the sea or border code,
// lies outside first_label..last_label, or the pixel is off the map.
// Boxes live in one 64-entry RAM, read at the edge that takes the request and
// written back in the following cycle; a one-entry forward register covers
// back-to-back pixels of the same label, so pixels and clears are taken one per
// cycle unless a stalled report holds the update stage. A report walks the
// tracked range, one RAM read per cycle while the result register is free, and
// sends one rsp_ result per label (box, center, tlast on the final label); no
// request is taken until its last read is issued. The first result passes the
// report counter, the update stage and the result register in that order.
// rsp_ holds a result register; when rsp_tready is low the report stage holds
// its entry and the walk pauses, nothing is lost.
// Reset (synchronous, active high) restores the configuration defaults and marks
// every box entry unwritten; unwritten entries read as the inverted extreme box,
// so reset and clear need no sweep of the RAM. The user writes the configuration
// through csr_we/csr_addr/csr_wdata only while idle; the block does not enforce it.
module label_bounding_box_tracker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // tdata: pixel_x[10:0], pixel_y[20:11], label[28:21], zero pad
   input  logic [lbbt_pkg::REQ_D_W-1:0]  req_tdata,
   // tuser: action[1:0]
   input  logic [1:0]                    req_tuser,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // tdata: region[5:0], box_left[16:6], box_top[26:17], box_right[37:27],
   //        box_bottom[47:38], center_col[58:48], center_row[68:59], zero pad
   output logic [lbbt_pkg::RSP_D_W-1:0]  rsp_tdata,
   output logic                          rsp_tlast,
   input  logic                          csr_we,
   input  logic [lbbt_pkg::CSR_A_W-1:0]  csr_addr,
   input  logic [lbbt_pkg::CSR_W-1:0]    csr_wdata
);

   lbbt_pkg::issue_type          issue;
   lbbt_pkg::report_type         report;
   logic                         advance;
   logic                         slot_free;
   logic                         ram_we;
   logic [lbbt_pkg::REG_W-1:0]   ram_waddr;
   logic [lbbt_pkg::BOX_W-1:0]   ram_wdata;
   logic [lbbt_pkg::BOX_W-1:0]   ram_rdata;
   logic                         ram_re;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [lbbt_pkg::RSP_D_W-1:0] rsp_data_ff, rsp_data_in;
   logic                         rsp_last_ff, rsp_last_in;

   logic [lbbt_pkg::X_W:0]       col_sum;
   logic [lbbt_pkg::Y_W:0]       row_sum;

   lbbt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .advance    (advance),
      .issue      (issue)
   );

   // Read the entry when the operation moves into the update stage.
   assign ram_re = advance && issue.valid;

   lbbt_ram #(
      .WIDTH (lbbt_pkg::BOX_W),
      .DEPTH (lbbt_pkg::SLOTS)
   ) u_box_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (issue.slot),
      .rdata (ram_rdata)
   );

   lbbt_update u_update (
      .clock     (clock),
      .reset     (reset),
      .issue     (issue),
      .ram_rdata (ram_rdata),
      .slot_free (slot_free),
      .advance   (advance),
      .ram_we    (ram_we),
      .ram_waddr (ram_waddr),
      .ram_wdata (ram_wdata),
      .report    (report)
   );

   // Result register: free when empty or being taken this cycle.
   assign slot_free = !rsp_valid_ff || rsp_tready;

   assign col_sum = {1'b0, report.box.min_col} + {1'b0, report.box.max_col};
   assign row_sum = {1'b0, report.box.min_row} + {1'b0, report.box.max_row};

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (report.valid && slot_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {{lbbt_pkg::RSP_PAD{1'b0}},
                         row_sum[lbbt_pkg::Y_W:1],
                         col_sum[lbbt_pkg::X_W:1],
                         report.box.max_row,
                         report.box.max_col,
                         report.box.min_row,
                         report.box.min_col,
                         report.region};
         rsp_last_in  = report.last;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

>>> verif/tb_top.sv
// Self-checking testbench of the label bounding box tracker with its own box predictor.
module tb_top;

   // One reported box as the result channel carries it.
   typedef struct packed {
      logic [lbbt_pkg::REG_W-1:0] region;
      logic [lbbt_pkg::X_W-1:0]   left;
      logic [lbbt_pkg::Y_W-1:0]   top;
      logic [lbbt_pkg::X_W-1:0]   right;
      logic [lbbt_pkg::Y_W-1:0]   bottom;
      logic [lbbt_pkg::X_W-1:0]   center_col;
      logic [lbbt_pkg::Y_W-1:0]   center_row;
      logic                       is_final;
   } box_report_type;

   localparam int SETTLE_CYCLES = 8;
   localparam int RUN_LIMIT     = 12 * 2_000_000;

   logic                           clock;
   logic                           reset      = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [lbbt_pkg::REQ_D_W-1:0]   req_tdata  = '0;
   logic [1:0]                     req_tuser  = lbbt_pkg::ACT_NONE;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [lbbt_pkg::RSP_D_W-1:0]   rsp_tdata;
   logic                           rsp_tlast;
   logic                           csr_we     = 1'b0;
   logic [lbbt_pkg::CSR_A_W-1:0]   csr_addr   = lbbt_pkg::CSR_FIRST;
   logic [lbbt_pkg::CSR_W-1:0]     csr_wdata  = '0;

   // Predicted configuration and box store.
   logic [lbbt_pkg::REG_W-1:0] cfg_first;
   logic [lbbt_pkg::REG_W-1:0] cfg_last;
   logic [lbbt_pkg::LAB_W-1:0] cfg_sea;
   logic [lbbt_pkg::LAB_W-1:0] cfg_border;
   logic [lbbt_pkg::X_W-1:0]   box_min_col [lbbt_pkg::SLOTS];
   logic [lbbt_pkg::Y_W-1:0]   box_min_row [lbbt_pkg::SLOTS];
   logic [lbbt_pkg::X_W-1:0]   box_max_col [lbbt_pkg::SLOTS];
   logic [lbbt_pkg::Y_W-1:0]   box_max_row [lbbt_pkg::SLOTS];

   box_report_type pending_boxes[$];
   int             error_count = 0;
   bit             steady      = 1'b0;   // no new gaps or stalls are drawn on either side while set
   int             stall_left  = 0;

   label_bounding_box_tracker u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // ---------------------------------------------------------------------
   // Box predictor
   // ---------------------------------------------------------------------

   // Return every box to the inverted extremes.
   function automatic void clear_boxes();
      for (int i = 0; i < lbbt_pkg::SLOTS; i++) begin
         box_min_col[i] = '1;
         box_min_row[i] = '1;
         box_max_col[i] = '0;
         box_max_row[i] = '0;
      end
   endfunction

   function automatic void restore_defaults();
      cfg_first  = '0;
      cfg_last   = lbbt_pkg::REG_W'(lbbt_pkg::MAX_LABELS - 1);
      cfg_sea    = '0;
      cfg_border = '1;
      clear_boxes();
   endfunction

   // Highest tracked label, cut to the number of labels the store holds.
   function automatic int top_label();
      return (int'(cfg_last) > lbbt_pkg::MAX_LABELS - 1) ? lbbt_pkg::MAX_LABELS - 1
                                                         : int'(cfg_last);
   endfunction

   // Update the store for one accepted request and queue the boxes it reports.
   function automatic void predict_request(lbbt_pkg::action_type act,
                                           logic [lbbt_pkg::X_W-1:0] x,
                                           logic [lbbt_pkg::Y_W-1:0] y,
                                           logic [lbbt_pkg::LAB_W-1:0] lab);
      int             hi;
      int             slot;
      box_report_type rep;
      hi = top_label();
      case (act)
         lbbt_pkg::ACT_PIXEL: begin
            if (int'(x) < lbbt_pkg::MAP_WIDTH && int'(y) < lbbt_pkg::MAP_HEIGHT &&
                lab != cfg_sea && lab != cfg_border &&
                int'(lab) >= int'(cfg_first) && int'(lab) <= hi) begin
               slot = int'(lab) % lbbt_pkg::SLOTS;
               if (x < box_min_col[slot]) box_min_col[slot] = x;
               if (y < box_min_row[slot]) box_min_row[slot] = y;
               if (x > box_max_col[slot]) box_max_col[slot] = x;
               if (y > box_max_row[slot]) box_max_row[slot] = y;
            end
         end
         lbbt_pkg::ACT_CLEAR: begin
            clear_boxes();
         end
         lbbt_pkg::ACT_REPORT: begin
            for (int r = int'(cfg_first); r <= hi; r++) begin
               slot           = r % lbbt_pkg::SLOTS;
               rep.region     = lbbt_pkg::REG_W'(r);
               rep.left       = box_min_col[slot];
               rep.top        = box_min_row[slot];
               rep.right      = box_max_col[slot];
               rep.bottom     = box_max_row[slot];
               rep.center_col = lbbt_pkg::X_W'(
                  (int'(box_min_col[slot]) + int'(box_max_col[slot])) >> 1);
               rep.center_row = lbbt_pkg::Y_W'(
                  (int'(box_min_row[slot]) + int'(box_max_row[slot])) >> 1);
               rep.is_final   = (r == hi);
               pending_boxes.push_back(rep);
            end
         end
         default: begin
            // unused action code: drop it
         end
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------

   // Mostly short gaps, a few long ones, none at all while steady.
   function automatic int pick_gap();
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(6, 24);
   endfunction

   // Send one request, hold it until accepted, then predict its effect.
   task automatic send_request(lbbt_pkg::action_type act,
                               logic [lbbt_pkg::X_W-1:0] x,
                               logic [lbbt_pkg::Y_W-1:0] y,
                               logic [lbbt_pkg::LAB_W-1:0] lab);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {{(lbbt_pkg::REQ_D_W - lbbt_pkg::X_W - lbbt_pkg::Y_W
                       - lbbt_pkg::LAB_W){1'b0}}, lab, y, x};
      do @(posedge clock); while (!req_tready);
      predict_request(act, x, y, lab);
   endtask

   // Drop valid, wait for every queued box, then let the pipeline settle.
   task automatic wait_idle(int settle);
      req_tvalid <= 1'b0;
      while (pending_boxes.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   // Write one register; only called while the block is idle.
   task automatic write_csr(lbbt_pkg::csr_type idx, logic [lbbt_pkg::CSR_W-1:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         lbbt_pkg::CSR_FIRST:  cfg_first  = value[lbbt_pkg::REG_W-1:0];
         lbbt_pkg::CSR_LAST:   cfg_last   = value[lbbt_pkg::REG_W-1:0];
         lbbt_pkg::CSR_SEA:    cfg_sea    = value[lbbt_pkg::LAB_W-1:0];
         lbbt_pkg::CSR_BORDER: cfg_border = value[lbbt_pkg::LAB_W-1:0];
         default:    ;
      endcase
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_all_csr(logic [lbbt_pkg::CSR_W-1:0] first,
                                logic [lbbt_pkg::CSR_W-1:0] last,
                                logic [lbbt_pkg::CSR_W-1:0] sea,
                                logic [lbbt_pkg::CSR_W-1:0] border);
      write_csr(lbbt_pkg::CSR_FIRST, first);
      write_csr(lbbt_pkg::CSR_LAST, last);
      write_csr(lbbt_pkg::CSR_SEA, sea);
      write_csr(lbbt_pkg::CSR_BORDER, border);
   endtask

   // ---------------------------------------------------------------------
   // Result side: check each accepted box, then pick the next ready level
   // ---------------------------------------------------------------------

   function automatic void check_field(string what, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      box_report_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_boxes.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual region %0d",
                     $time, rsp_tdata[5:0]);
            error_count++;
         end else begin
            want = pending_boxes.pop_front();
            check_field("region",     want.region,     rsp_tdata[5:0]);
            check_field("box_left",   want.left,       rsp_tdata[16:6]);
            check_field("box_top",    want.top,        rsp_tdata[26:17]);
            check_field("box_right",  want.right,      rsp_tdata[37:27]);
            check_field("box_bottom", want.bottom,     rsp_tdata[47:38]);
            check_field("center_col", want.center_col, rsp_tdata[58:48]);
            check_field("center_row", want.center_row, rsp_tdata[68:59]);
            check_field("tlast",      want.is_final,   rsp_tlast);
         end
      end
      // Hold off the receiver now and then; mostly short stalls, a few long.
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (!steady && $urandom_range(0, 99) < 20) begin
         rsp_tready <= 1'b0;
         stall_left <= ($urandom_range(0, 9) < 8) ? int'($urandom_range(0, 2))
                                                  : int'($urandom_range(6, 30));
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Right after reset every box is unseen; the unused action is ignored.
   task automatic test_reset_state();
      send_request(lbbt_pkg::ACT_NONE, lbbt_pkg::X_W'($urandom), lbbt_pkg::Y_W'($urandom),
                   lbbt_pkg::LAB_W'($urandom));
      send_request(lbbt_pkg::ACT_REPORT, '0, '0, '0);
      wait_idle(SETTLE_CYCLES);
   endtask

   // Corner coordinates, same-label bursts, sea/border and out-of-range labels.
   task automatic test_pixel_extremes();
      send_request(lbbt_pkg::ACT_PIXEL, 11'd0,    10'd0,    8'd1);
      send_request(lbbt_pkg::ACT_PIXEL, 11'd2047, 10'd1023, 8'd1);
      send_request(lbbt_pkg::ACT_PIXEL, 11'd5,    10'd7,    8'd2);
      send_request(lbbt_pkg::ACT_PIXEL, 11'd5,    10'd7,    8'd2);
      send_request(lbbt_pkg::ACT_PIXEL, 11'd3,    10'd9,    8'd2);
      send_request(lbbt_pkg::ACT_PIXEL, 11'd1,    10'd900,  8'd2);
      send_request(lbbt_pkg::ACT_PIXEL, 11'd2047, 10'd0,    8'd63);
      send_request(lbbt_pkg::ACT_PIXEL, 11'd1234, 10'd345,  8'd0);    // sea code
      send_request(lbbt_pkg::ACT_PIXEL, 11'd1234, 10'd345,  8'd255);  // border code
      send_request(lbbt_pkg::ACT_PIXEL, 11'd1234, 10'd345,  8'd64);   // above the range
      send_request(lbbt_pkg::ACT_PIXEL, 11'd1234, 10'd345,  8'd128);
      send_request(lbbt_pkg::ACT_PIXEL, 11'd1234, 10'd345,  8'd200);
      send_request(lbbt_pkg::ACT_NONE,  11'h555,  10'h2AA,  8'd3);
      send_request(lbbt_pkg::ACT_REPORT, '0, '0, '0);
      send_request(lbbt_pkg::ACT_CLEAR,  '0, '0, '0);
      send_request(lbbt_pkg::ACT_PIXEL, 11'd1000, 10'd500,  8'd3);
      send_request(lbbt_pkg::ACT_REPORT, '0, '0, '0);
      wait_idle(SETTLE_CYCLES);
   endtask

   // Narrow, single-label, empty and inverted ranges; sea and border inside range.
   task automatic test_config_ranges();
      write_all_csr(8'd5, 8'd9, 8'd6, 8'd8);
      for (int lab = 5; lab <= 9; lab++) begin
         send_request(lbbt_pkg::ACT_PIXEL, lbbt_pkg::X_W'($urandom),
                      lbbt_pkg::Y_W'($urandom), lbbt_pkg::LAB_W'(lab));
         send_request(lbbt_pkg::ACT_PIXEL, lbbt_pkg::X_W'($urandom),
                      lbbt_pkg::Y_W'($urandom), lbbt_pkg::LAB_W'(lab));
      end
      send_request(lbbt_pkg::ACT_REPORT, '0, '0, '0);
      wait_idle(SETTLE_CYCLES);

      // first above last: nothing tracked, nothing reported
      write_all_csr(8'd10, 8'd3, 8'd0, 8'd255);
      send_request(lbbt_pkg::ACT_PIXEL, 11'd7, 10'd7, 8'd5);
      send_request(lbbt_pkg::ACT_REPORT, '0, '0, '0);
      wait_idle(SETTLE_CYCLES);

      // upper write-data bits are dropped: both ends land on the top label
      write_all_csr(8'hFF, 8'hFF, 8'h00, 8'hFF);
      send_request(lbbt_pkg::ACT_PIXEL, 11'd2047, 10'd1023, 8'd63);
      send_request(lbbt_pkg::ACT_PIXEL, 11'd0,    10'd512,  8'd63);
      send_request(lbbt_pkg::ACT_REPORT, '0, '0, '0);
      wait_idle(SETTLE_CYCLES);

      write_all_csr(8'd0, 8'd0, 8'hAA, 8'h55);
      send_request(lbbt_pkg::ACT_PIXEL, 11'd0,    10'd1023, 8'd0);
      send_request(lbbt_pkg::ACT_PIXEL, 11'd2047, 10'd0,    8'd0);
      send_request(lbbt_pkg::ACT_REPORT, '0, '0, '0);
      wait_idle(SETTLE_CYCLES);
   endtask

   function automatic logic [lbbt_pkg::X_W-1:0] pick_col();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r == 1) return '1;
      return lbbt_pkg::X_W'($urandom);
   endfunction

   function automatic logic [lbbt_pkg::Y_W-1:0] pick_row();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r == 1) return '1;
      return lbbt_pkg::Y_W'($urandom);
   endfunction

   // Random ranges per phase; mostly tracked pixels with reports and clears between.
   task automatic test_random_traffic(int phases, int per_phase);
      int                         hi;
      int                         r;
      int                         shape;
      int                         span;
      logic [lbbt_pkg::CSR_W-1:0] first;
      logic [lbbt_pkg::CSR_W-1:0] last;
      logic [lbbt_pkg::LAB_W-1:0] lab;
      for (int p = 0; p < phases; p++) begin
         steady = (p == 1);
         shape  = $urandom_range(0, 9);
         first  = lbbt_pkg::CSR_W'($urandom_range(0, 63));
         if (shape == 0) begin
            first = 8'd0;
            last  = 8'd63;
         end else if (shape == 1) begin
            last = lbbt_pkg::CSR_W'($urandom_range(0, 63));       // may be empty
         end else begin
            span = $urandom_range(0, 12);
            last = (int'(first) + span > 63) ? 8'd63 : lbbt_pkg::CSR_W'(int'(first) + span);
         end
         // place sea or border inside the range now and then
         write_all_csr(first | lbbt_pkg::CSR_W'($urandom_range(0, 3) << lbbt_pkg::REG_W),
                       last  | lbbt_pkg::CSR_W'($urandom_range(0, 3) << lbbt_pkg::REG_W),
                       ($urandom_range(0, 2) == 0) ? first + 8'd1
                                                   : lbbt_pkg::CSR_W'($urandom_range(0, 255)),
                       ($urandom_range(0, 2) == 0) ? last
                                                   : lbbt_pkg::CSR_W'($urandom_range(0, 255)));
         hi = top_label();
         for (int i = 0; i < per_phase; i++) begin
            // pause once until every box is back, mid-stream
            if (p == 2 && i == per_phase / 2) wait_idle(0);
            r = $urandom_range(0, 99);
            if (int'(cfg_first) <= hi && r < 70)
               lab = lbbt_pkg::LAB_W'($urandom_range(int'(cfg_first), hi));
            else
               lab = lbbt_pkg::LAB_W'($urandom_range(0, 255));
            if (r < 82)
               send_request(lbbt_pkg::ACT_PIXEL, pick_col(), pick_row(), lab);
            else if (r < 92)
               send_request(lbbt_pkg::ACT_REPORT, lbbt_pkg::X_W'($urandom),
                            lbbt_pkg::Y_W'($urandom), lbbt_pkg::LAB_W'($urandom));
            else if (r < 96)
               send_request(lbbt_pkg::ACT_CLEAR, lbbt_pkg::X_W'($urandom),
                            lbbt_pkg::Y_W'($urandom), lbbt_pkg::LAB_W'($urandom));
            else
               send_request(lbbt_pkg::ACT_NONE, lbbt_pkg::X_W'($urandom),
                            lbbt_pkg::Y_W'($urandom), lbbt_pkg::LAB_W'($urandom));
         end
         send_request(lbbt_pkg::ACT_REPORT, '0, '0, '0);
         wait_idle(SETTLE_CYCLES);
      end
      steady = 1'b0;
      write_all_csr(8'd0, 8'd63, 8'd0, 8'd255);
   endtask

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------

   initial begin
      restore_defaults();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_state();
      test_pixel_extremes();
      test_config_ranges();
      test_random_traffic(4, 32);
      send_request(lbbt_pkg::ACT_REPORT, '0, '0, '0);
      wait_idle(SETTLE_CYCLES);
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Bound the run well past the slowest legal schedule.
   initial begin
      #(RUN_LIMIT);
      $display("%0t: timeout with %0d boxes outstanding", $time, pending_boxes.size());
      $display("== FAIL ==");
      $finish;
   end

endmodule
